// ===== sv/jls_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jls_pkg
// Shared types and constants for the Jacobi sweep block.
// ----------------------------------------------------------------------------
package jls_pkg;

  // Largest grid side held in the banks; the row and column fields are sized
  // for it.
  localparam int MAX_SIDE = 64;

  typedef enum logic [1:0] {
    KIND_INIT  = 2'd0,
    KIND_SWEEP = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_GRID_SIZE  = 2'd0,
    CFG_INIT_VALUE = 2'd1,
    CFG_RHS_VALUE  = 2'd2,
    CFG_H_SCALE    = 2'd3
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SWEEP,
    ST_SWEEP_DRAIN,
    ST_SQRT,
    ST_SCALE,
    ST_READ,
    ST_READ_WAIT,
    ST_DONE,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start_init;
    logic start_sweep;
    logic start_read;
    logic start_sqrt;
    logic start_scale;
    logic latch_read;
    logic clear_result;
    logic finish_sweep;
  } jls_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic init_done;
    logic scan_done;
    logic pipe_empty;
    logic sqrt_done;
  } jls_sts_t;

endpackage

`default_nettype wire

// ===== sv/jls_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jls_req_if / jls_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface jls_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [5:0] row;
  logic [5:0] col;
  modport source (output valid, kind, row, col, input ready);
  modport sink   (input valid, kind, row, col, output ready);
endinterface

interface jls_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] residual;
  logic [31:0] cell_value;
  logic [15:0] sweep_number;
  logic        out_of_range;
  modport source (output valid, residual, cell_value, sweep_number, out_of_range,
                  input ready);
  modport sink   (input valid, residual, cell_value, sweep_number, out_of_range,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/jls_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jls_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module jls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

`default_nettype wire

// ===== sv/jls_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jls_ctrl
// Request sequencer: starts the datapath operations and hands out results.
// ----------------------------------------------------------------------------
module jls_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  input  wire logic [1:0]        req_kind,
  output logic                   req_ready,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output jls_pkg::jls_cmd_t      cmd,
  input  wire jls_pkg::jls_sts_t sts
);
  jls_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jls_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      jls_pkg::ST_IDLE: begin
        if (req_valid) begin
          case (jls_pkg::kind_t'(req_kind))
            jls_pkg::KIND_INIT:  state_next = jls_pkg::ST_INIT;
            jls_pkg::KIND_SWEEP: state_next = jls_pkg::ST_SWEEP;
            jls_pkg::KIND_READ:  state_next = jls_pkg::ST_READ;
            default:             state_next = jls_pkg::ST_DONE;
          endcase
        end
      end
      jls_pkg::ST_INIT:        if (sts.init_done) state_next = jls_pkg::ST_DONE;
      jls_pkg::ST_SWEEP:       if (sts.scan_done) state_next = jls_pkg::ST_SWEEP_DRAIN;
      jls_pkg::ST_SWEEP_DRAIN: if (sts.pipe_empty) state_next = jls_pkg::ST_SQRT;
      jls_pkg::ST_SQRT:        if (sts.sqrt_done) state_next = jls_pkg::ST_SCALE;
      jls_pkg::ST_SCALE:       state_next = jls_pkg::ST_DONE;
      jls_pkg::ST_READ:        state_next = jls_pkg::ST_READ_WAIT;
      jls_pkg::ST_READ_WAIT:   state_next = jls_pkg::ST_DONE;
      jls_pkg::ST_DONE:        state_next = jls_pkg::ST_OUT;
      jls_pkg::ST_OUT:         if (rsp_ready) state_next = jls_pkg::ST_IDLE;
      default:                 state_next = jls_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    req_ready = 1'b0;
    rsp_valid = 1'b0;
    case (state)
      jls_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        cmd.clear_result = req_valid;
        if (req_valid) begin
          case (jls_pkg::kind_t'(req_kind))
            jls_pkg::KIND_INIT:  cmd.start_init = 1'b1;
            jls_pkg::KIND_SWEEP: cmd.start_sweep = 1'b1;
            jls_pkg::KIND_READ:  cmd.start_read = 1'b1;
            default:             ;
          endcase
        end
      end
      jls_pkg::ST_SWEEP_DRAIN: cmd.start_sqrt = sts.pipe_empty;
      jls_pkg::ST_SQRT:        cmd.start_scale = sts.sqrt_done;
      jls_pkg::ST_SCALE:       cmd.finish_sweep = 1'b1;
      // The cell word fetched at acceptance is on the RAM output only now.
      jls_pkg::ST_READ:        cmd.latch_read = 1'b1;
      jls_pkg::ST_OUT:         rsp_valid = 1'b1;
      default:                 ;
    endcase
  end
endmodule

`default_nettype wire

// ===== sv/jls_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jls_dp
// Datapath: two grid banks, stencil pipeline, residual accumulator,
// bit-serial square root and the final scaling.
// ----------------------------------------------------------------------------
module jls_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire jls_pkg::jls_cmd_t cmd,
  output jls_pkg::jls_sts_t      sts,
  input  wire logic [5:0]        req_row,
  input  wire logic [5:0]        req_col,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [31:0]       cfg_data,
  output logic [31:0]            residual,
  output logic [31:0]            cell_value,
  output logic [15:0]            sweep_number,
  output logic                   out_of_range
);
  localparam int SW = $clog2(jls_pkg::MAX_SIDE);
  localparam int AW = 2 * SW;
  localparam int DEPTH = jls_pkg::MAX_SIDE * jls_pkg::MAX_SIDE;
  localparam int CW = SW + 1;

  // Configuration registers.
  logic [6:0]  grid_size;
  logic [31:0] init_value;
  logic [31:0] rhs_value;
  logic [30:0] h_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size  <= 7'd4;
      init_value <= 32'd536870912;
      rhs_value  <= 32'd42949673;
      h_scale    <= 31'd214748365;
    end else if (cfg_we) begin
      case (jls_pkg::cfg_index_t'(cfg_index))
        jls_pkg::CFG_GRID_SIZE:  grid_size  <= cfg_data[6:0];
        jls_pkg::CFG_INIT_VALUE: init_value <= cfg_data;
        jls_pkg::CFG_RHS_VALUE:  rhs_value  <= cfg_data;
        jls_pkg::CFG_H_SCALE:    h_scale    <= cfg_data[30:0];
        default:                 ;
      endcase
    end
  end

  // Side length in use, limited to MAX_SIDE.
  logic [CW-1:0] side;
  always_comb begin
    if ({25'd0, grid_size} > jls_pkg::MAX_SIDE) begin
      side = CW'(jls_pkg::MAX_SIDE);
    end else begin
      side = CW'(grid_size);
    end
  end

  logic        current_bank;
  logic [15:0] sweep_counter;

  // Sweep scan: the centre cell is fetched, then its four neighbours, one per
  // cycle, from the source bank. Phase 0 centre, 1 up, 2 down, 3 left, 4 right.
  logic          busy_init, busy_scan;
  logic [AW-1:0] init_addr;
  logic [SW-1:0] sr, sc;
  logic [2:0]    phase;

  // Address and validity of the current fetch.
  logic [CW:0]   fr, fc;
  logic          f_ok;
  always_comb begin
    fr = {1'b0, CW'(sr)};
    fc = {1'b0, CW'(sc)};
    case (phase)
      3'd1:    fr = {1'b0, CW'(sr)} - 1'b1;
      3'd2:    fr = {1'b0, CW'(sr)} + 1'b1;
      3'd3:    fc = {1'b0, CW'(sc)} - 1'b1;
      3'd4:    fc = {1'b0, CW'(sc)} + 1'b1;
      default: ;
    endcase
    f_ok = (fr < {1'b0, side}) && (fc < {1'b0, side});
  end

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  logic [31:0]   wr_data;
  logic [31:0]   rdata_a, rdata_b;
  logic [AW-1:0] addr_a, addr_b;
  logic          we_a, we_b;
  logic [31:0]   wd_a, wd_b;

  always_comb begin
    rd_addr = {fr[SW-1:0], fc[SW-1:0]};
    if (busy_init) begin
      addr_a = init_addr; addr_b = init_addr;
      we_a = 1'b1; we_b = 1'b1;
      wd_a = init_value; wd_b = init_value;
    end else begin
      addr_a = rd_addr; addr_b = rd_addr;
      we_a = 1'b0; we_b = 1'b0;
      wd_a = wr_data; wd_b = wr_data;
      if (cmd.start_read) begin
        addr_a = {req_row[SW-1:0], req_col[SW-1:0]};
        addr_b = {req_row[SW-1:0], req_col[SW-1:0]};
      end
      if (wr_en) begin
        if (current_bank) begin
          addr_a = wr_addr; we_a = 1'b1;
        end else begin
          addr_b = wr_addr; we_b = 1'b1;
        end
      end
    end
  end

  jls_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_bank_a (
    .clk(clk), .we(we_a), .addr(addr_a), .wdata(wd_a), .rdata(rdata_a)
  );
  jls_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_bank_b (
    .clk(clk), .we(we_b), .addr(addr_b), .wdata(wd_b), .rdata(rdata_b)
  );

  logic [31:0] src_rdata;
  assign src_rdata = current_bank ? rdata_b : rdata_a;

  // Fetch tracking: the RAM data arrives in the cycle after the address.
  logic          d_valid, d_ok;
  logic [2:0]    d_phase;
  logic [AW-1:0] d_addr;

  logic signed [31:0] u_reg;
  logic signed [34:0] nb_sum;
  logic               calc_valid;
  logic signed [34:0] calc_nb;
  logic signed [31:0] calc_u;
  logic [AW-1:0]      calc_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_init <= 1'b0;
      busy_scan <= 1'b0;
      d_valid   <= 1'b0;
      calc_valid <= 1'b0;
    end else begin
      if (cmd.start_init) begin
        busy_init <= 1'b1;
        init_addr <= '0;
      end else if (busy_init) begin
        init_addr <= init_addr + 1'b1;
        if (init_addr == AW'(DEPTH - 1)) busy_init <= 1'b0;
      end
      if (cmd.start_sweep) begin
        busy_scan <= (side != '0);
        sr <= '0; sc <= '0; phase <= '0;
      end else if (busy_scan) begin
        if (phase == 3'd4) begin
          phase <= '0;
          if ({1'b0, sc} == side - 1'b1) begin
            sc <= '0;
            if ({1'b0, sr} == side - 1'b1) busy_scan <= 1'b0;
            else sr <= sr + 1'b1;
          end else begin
            sc <= sc + 1'b1;
          end
        end else begin
          phase <= phase + 1'b1;
        end
      end
      d_valid <= busy_scan;
      calc_valid <= d_valid && (d_phase == 3'd4);
    end
  end

  always_ff @(posedge clk) begin
    logic signed [31:0] v;
    v = d_ok ? $signed(src_rdata) : 32'sd0;
    d_phase <= phase;
    d_ok    <= f_ok;
    d_addr  <= {sr, sc};
    if (d_valid) begin
      if (d_phase == 3'd0) begin
        u_reg <= v;
        nb_sum <= '0;
      end else begin
        nb_sum <= nb_sum + 35'(v);
      end
      if (d_phase == 3'd4) begin
        calc_nb   <= nb_sum + 35'(v);
        calc_u    <= u_reg;
        calc_addr <= d_addr;
      end
    end
  end

  // New value and residual term.
  logic signed [35:0] upd_sum, res_full;
  logic signed [31:0] upd_sat, res_sat;
  always_comb begin
    upd_sum = 36'(calc_nb) + 36'($signed(rhs_value));
    // Arithmetic shift gives the floor of the quarter.
    if ((upd_sum >>> 2) > 36'sd2147483647)       upd_sat = 32'h7fffffff;
    else if ((upd_sum >>> 2) < -36'sd2147483648) upd_sat = 32'h80000000;
    else                                          upd_sat = upd_sum[33:2];
    res_full = (36'(calc_u) <<< 2) - 36'(calc_nb) - 36'($signed(rhs_value));
    if (res_full > 36'sd2147483647)       res_sat = 32'h7fffffff;
    else if (res_full < -36'sd2147483648) res_sat = 32'h80000000;
    else                                   res_sat = res_full[31:0];
  end

  assign wr_en   = calc_valid && !busy_init;
  assign wr_addr = calc_addr;
  assign wr_data = upd_sat;

  // Square stage, then saturating accumulate.
  logic        sq_valid;
  logic [63:0] sq;
  logic [63:0] acc;
  logic [31:0] mag;
  logic [64:0] acc_sum;
  assign mag = res_sat[31] ? 32'(-res_sat) : res_sat;
  assign acc_sum = {1'b0, acc} + {1'b0, sq};

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else begin
      sq_valid <= calc_valid;
    end
    sq <= {32'd0, mag} * {32'd0, mag};
    if (cmd.start_sweep) begin
      acc <= '0;
    end else if (sq_valid) begin
      acc <= acc_sum[64] ? 64'hffffffffffffffff : acc_sum[63:0];
    end
  end

  assign sts.init_done  = busy_init && (init_addr == AW'(DEPTH - 1));
  assign sts.scan_done  = !busy_scan;
  assign sts.pipe_empty = !busy_scan && !d_valid && !calc_valid && !sq_valid;

  // Bit-serial floor square root, two radicand bits per cycle.
  logic [63:0] sq_rem;
  logic [33:0] sq_root;
  logic [5:0]  sq_cnt;
  logic        sq_busy;
  logic [63:0] rad;
  always_ff @(posedge clk) begin
    logic [65:0] r2;
    logic [65:0] t;
    if (rst) begin
      sq_busy <= 1'b0;
    end else if (cmd.start_sqrt) begin
      sq_busy <= 1'b1;
      sq_cnt  <= '0;
      sq_rem  <= '0;
      sq_root <= '0;
      rad     <= acc;
    end else if (sq_busy) begin
      r2 = {sq_rem, rad[63:62]};
      t  = {30'd0, sq_root, 2'b01};
      if (r2 >= t) begin
        sq_rem  <= 64'(r2 - t);
        sq_root <= {sq_root[32:0], 1'b1};
      end else begin
        sq_rem  <= r2[63:0];
        sq_root <= {sq_root[32:0], 1'b0};
      end
      rad    <= {rad[61:0], 2'b00};
      sq_cnt <= sq_cnt + 1'b1;
      if (sq_cnt == 6'd31) sq_busy <= 1'b0;
    end
  end
  assign sts.sqrt_done = !sq_busy && !cmd.start_sqrt;

  // Scale: one 31 x 32 product, registered, then shift and saturate.
  logic [62:0] prod;
  logic [32:0] prod_sh;
  logic [5:0]  rd_row, rd_col;
  assign prod_sh = prod[62:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      current_bank  <= 1'b0;
      sweep_counter <= '0;
    end else if (cmd.start_init) begin
      current_bank  <= 1'b0;
      sweep_counter <= '0;
    end else if (cmd.finish_sweep) begin
      current_bank  <= ~current_bank;
      sweep_counter <= sweep_counter + 1'b1;
    end
    if (cmd.start_scale) begin
      prod <= {32'd0, h_scale} * {31'd0, sq_root[31:0]};
    end
    if (cmd.clear_result) begin
      residual     <= '0;
      cell_value   <= '0;
      out_of_range <= 1'b0;
    end
    if (cmd.finish_sweep) begin
      residual <= prod_sh[32] ? 32'hffffffff : prod_sh[31:0];
    end
    if (cmd.start_read) begin
      rd_row <= req_row;
      rd_col <= req_col;
    end
    if (cmd.latch_read) begin
      if ({1'b0, rd_row} >= {1'b0, side} || {1'b0, rd_col} >= {1'b0, side}) begin
        out_of_range <= 1'b1;
      end else begin
        cell_value <= src_rdata;
      end
    end
  end

  assign sweep_number = sweep_counter;
endmodule

`default_nettype wire

// ===== sv/jacobi_laplace_sweep.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jacobi_laplace_sweep
// Jacobi solver for the five-point Laplace stencil on a square Q2.30 grid.
// ----------------------------------------------------------------------------
// Usage: requests enter on req (kind, row, col) and each request gives exactly
// one result on rsp. Kind 0 fills both banks with init_value, one RAM word a
// cycle, then offers its result. Kind 1 runs one sweep: every used cell takes
// five source-bank reads on the single RAM port, and the result is offered
// after the scan, the pipeline drain and the 32-step square root. Kind 2 reads
// one cell; the unused kind only answers.
// One request is handled at a time; ready is high only while idle.
// A result is held on rsp until taken, and no request is accepted meanwhile.
// Reset clears the controller, the bank select, the sweep count and loads the
// register defaults; grid contents are undefined until an init request.
// Configuration writes land on the next clock edge and should be made idle.
// ----------------------------------------------------------------------------
module jacobi_laplace_sweep (
  input  wire logic        clk,
  input  wire logic        rst,
  jls_req_if.sink          req,
  jls_rsp_if.source        rsp,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  jls_pkg::jls_cmd_t cmd;
  jls_pkg::jls_sts_t sts;

  jls_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .req_valid(req.valid), .req_kind(req.kind), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .cmd(cmd), .sts(sts)
  );

  jls_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .req_row(req.row), .req_col(req.col),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .residual(rsp.residual), .cell_value(rsp.cell_value),
    .sweep_number(rsp.sweep_number), .out_of_range(rsp.out_of_range)
  );
endmodule

`default_nettype wire

// ===== tb/sv/jacobi_laplace_sweep_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jacobi_laplace_sweep_test
// Self-checking bench for the Jacobi sweep block. An in-bench copy of the
// two grid banks and the registers predicts every result. Directed requests
// cover the extremes and the special cases. Random phases then change the
// registers while the block is idle and send bursts of requests, with
// random stalls on the result side.
// ----------------------------------------------------------------------------
module jacobi_laplace_sweep_test;

  localparam int SIDE       = jls_pkg::MAX_SIDE;
  localparam int CYCLE_CAP  = 12000000;

  typedef struct {
    logic [31:0] residual;
    logic [31:0] cell_value;
    logic [15:0] sweep_number;
    logic        out_of_range;
  } outcome_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  jls_req_if req_ch ();
  jls_rsp_if rsp_ch ();

  jacobi_laplace_sweep uut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the block's state and registers.
  logic signed [31:0] bank0 [0:SIDE*SIDE-1];
  logic signed [31:0] bank1 [0:SIDE*SIDE-1];
  logic               live_bank;
  logic [15:0]        sweeps_done;
  logic [6:0]         side_reg;
  logic signed [31:0] init_reg;
  logic signed [31:0] rhs_reg;
  logic [30:0]        step_reg;

  outcome_t pending_results[$];
  int       errors;
  int       cycle_count;
  int       hold_cycles;
  bit       rx_stalls;
  bit       bursty;
  int       burst_left;
  int       n_sweeps, n_reads, n_inits, n_writes;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("jacobi_laplace_sweep regression: fail");
      $finish;
    end
  end

  // Receiver: a long hold-off when asked, otherwise random stalls when enabled, else always ready.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_cycles  <= hold_cycles - 1;
    end else if (rx_stalls) begin
      rsp_ch.ready <= ($urandom_range(0, 99) < 55);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h (cycle %0d)", what, got, want, cycle_count);
    errors++;
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", rsp_ch.cell_value, 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.residual !== want.residual)
          report_mismatch("residual", rsp_ch.residual, want.residual);
        if (rsp_ch.cell_value !== want.cell_value)
          report_mismatch("cell_value", rsp_ch.cell_value, want.cell_value);
        if (rsp_ch.sweep_number !== want.sweep_number)
          report_mismatch("sweep_number", 32'(rsp_ch.sweep_number),
                          32'(want.sweep_number));
        if (rsp_ch.out_of_range !== want.out_of_range)
          report_mismatch("out_of_range", 32'(rsp_ch.out_of_range),
                          32'(want.out_of_range));
      end
    end
  end

  function automatic int used_side();
    return (side_reg > SIDE) ? SIDE : int'(side_reg);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint grid_cell(bit b, int r, int c, int n);
    if (r < 0 || c < 0 || r >= n || c >= n) return 0;
    return b ? longint'(bank1[r*SIDE+c]) : longint'(bank0[r*SIDE+c]);
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitpos;
    root   = 0;
    bitpos = 64'h1 << 62;
    while (bitpos > v) bitpos = bitpos >> 2;
    while (bitpos != 0) begin
      if (v >= root + bitpos) begin
        v    = v - (root + bitpos);
        root = (root >> 1) + bitpos;
      end else begin
        root = root >> 1;
      end
      bitpos = bitpos >> 2;
    end
    return root;
  endfunction

  // One Jacobi sweep on the shadow banks; returns the scaled residual norm.
  function automatic logic [31:0] sweep_residual();
    int          n;
    longint      u, nb, t;
    logic [63:0] mag, sq, acc, prod;
    logic [64:0] wide;
    n   = used_side();
    acc = 0;
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        u  = grid_cell(live_bank, r, c, n);
        nb = grid_cell(live_bank, r-1, c, n) + grid_cell(live_bank, r+1, c, n)
           + grid_cell(live_bank, r, c-1, n) + grid_cell(live_bank, r, c+1, n);
        t   = clamp32(4*u - nb - longint'(rhs_reg));
        mag = (t < 0) ? 64'(-t) : 64'(t);
        sq  = mag * mag;
        if (live_bank) bank0[r*SIDE+c] = 32'(clamp32((nb + longint'(rhs_reg)) >>> 2));
        else           bank1[r*SIDE+c] = 32'(clamp32((nb + longint'(rhs_reg)) >>> 2));
        wide = {1'b0, acc} + {1'b0, sq};
        acc  = wide[64] ? 64'hFFFF_FFFF_FFFF_FFFF : wide[63:0];
      end
    end
    prod = (64'(step_reg) * floor_sqrt(acc)) >> 30;
    live_bank   = ~live_bank;
    sweeps_done = sweeps_done + 16'd1;
    return (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
  endfunction

  function automatic outcome_t predict_request(jls_pkg::kind_t kind, logic [5:0] row,
                                               logic [5:0] col);
    outcome_t res;
    int       n;
    res = '{residual: 32'h0, cell_value: 32'h0, sweep_number: 16'h0, out_of_range: 1'b0};
    n   = used_side();
    case (kind)
      jls_pkg::KIND_INIT: begin
        for (int i = 0; i < SIDE*SIDE; i++) begin
          bank0[i] = init_reg;
          bank1[i] = init_reg;
        end
        live_bank   = 1'b0;
        sweeps_done = 16'h0;
        n_inits++;
      end
      jls_pkg::KIND_SWEEP: begin
        res.residual = sweep_residual();
        n_sweeps++;
      end
      jls_pkg::KIND_READ: begin
        if (int'(row) >= n || int'(col) >= n) res.out_of_range = 1'b1;
        else res.cell_value = 32'(grid_cell(live_bank, int'(row), int'(col), n));
        n_reads++;
      end
      default: ;
    endcase
    res.sweep_number = sweeps_done;
    return res;
  endfunction

  // Offers one request, waits for the handshake and records the expectation.
  task automatic send_request(jls_pkg::kind_t kind, logic [5:0] row, logic [5:0] col);
    int gap;
    req_ch.valid <= 1'b1;
    req_ch.kind  <= kind;
    req_ch.row   <= row;
    req_ch.col   <= col;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(predict_request(kind, row, col));
    if (bursty) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 12);
        burst_left = $urandom_range(1, 8);
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(jls_pkg::cfg_index_t idx, logic [31:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      jls_pkg::CFG_GRID_SIZE:  side_reg = data[6:0];
      jls_pkg::CFG_INIT_VALUE: init_reg = data;
      jls_pkg::CFG_RHS_VALUE:  rhs_reg  = data;
      jls_pkg::CFG_H_SCALE:    step_reg = data[30:0];
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic set_all(logic [31:0] side, logic [31:0] init, logic [31:0] rhs,
                         logic [31:0] step);
    drain_results();
    write_reg(jls_pkg::CFG_GRID_SIZE, side);
    write_reg(jls_pkg::CFG_INIT_VALUE, init);
    write_reg(jls_pkg::CFG_RHS_VALUE, rhs);
    write_reg(jls_pkg::CFG_H_SCALE, step);
    @(posedge clk);
  endtask

  // Reset defaults: init, reads at the corners and beyond, sweeps, idle kind.
  task automatic test_defaults();
    send_request(jls_pkg::KIND_INIT, 6'd0, 6'd0);
    send_request(jls_pkg::KIND_READ, 6'd0, 6'd0);
    send_request(jls_pkg::KIND_READ, 6'd3, 6'd3);
    send_request(jls_pkg::KIND_READ, 6'd4, 6'd0);
    send_request(jls_pkg::KIND_READ, 6'd63, 6'd63);
    send_request(jls_pkg::KIND_SWEEP, 6'd0, 6'd0);
    send_request(jls_pkg::KIND_READ, 6'd1, 6'd2);
    send_request(jls_pkg::KIND_SWEEP, 6'd63, 6'd63);
    send_request(jls_pkg::KIND_NONE, 6'd21, 6'd42);
    send_request(jls_pkg::KIND_READ, 6'd0, 6'd3);
  endtask

  // Empty grid, oversized grid and the saturating corners of the arithmetic.
  task automatic test_special_cases();
    set_all(32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h4000_0000);
    send_request(jls_pkg::KIND_INIT, 6'd0, 6'd0);
    send_request(jls_pkg::KIND_SWEEP, 6'd0, 6'd0);
    send_request(jls_pkg::KIND_READ, 6'd0, 6'd0);
    set_all(32'd127, 32'h1234_5678, 32'h0000_0000, 32'h0000_0000);
    send_request(jls_pkg::KIND_INIT, 6'd0, 6'd0);
    send_request(jls_pkg::KIND_SWEEP, 6'd0, 6'd0);
    send_request(jls_pkg::KIND_READ, 6'd63, 6'd63);
    send_request(jls_pkg::KIND_READ, 6'd63, 6'd0);
    // Minimum cells against maximum forcing drive the sum of squares to its ceiling.
    set_all(32'd3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h4000_0000);
    send_request(jls_pkg::KIND_INIT, 6'd0, 6'd0);
    send_request(jls_pkg::KIND_SWEEP, 6'd0, 6'd0);
    send_request(jls_pkg::KIND_READ, 6'd1, 6'd1);
    send_request(jls_pkg::KIND_SWEEP, 6'd0, 6'd0);
    set_all(32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_request(jls_pkg::KIND_INIT, 6'd0, 6'd0);
    send_request(jls_pkg::KIND_SWEEP, 6'd0, 6'd0);
    send_request(jls_pkg::KIND_READ, 6'd0, 6'd0);
    send_request(jls_pkg::KIND_READ, 6'd0, 6'd1);
  endtask

  // The receiver holds off while reads and sweeps keep arriving, so the input stalls.
  task automatic test_backpressure();
    set_all(32'd5, 32'h0123_4567, 32'hFEDC_BA98, 32'd214748365);
    send_request(jls_pkg::KIND_INIT, 6'd0, 6'd0);
    drain_results();
    hold_cycles = 2000;
    for (int i = 0; i < 6; i++)
      send_request(i[0] ? jls_pkg::KIND_SWEEP : jls_pkg::KIND_READ,
                   6'($urandom_range(0, 5)), 6'($urandom_range(0, 5)));
    drain_results();
  endtask

  function automatic logic [31:0] random_side();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5)  return 32'd0;
    if (pick < 8)  return 32'($urandom_range(64, 127));
    if (pick < 20) return 32'($urandom_range(7, 16));
    return 32'($urandom_range(1, 6));
  endfunction

  task automatic test_random(int total);
    int             sent;
    int             pick;
    int             n;
    jls_pkg::kind_t kind;
    logic [5:0]     row, col;
    sent   = 0;
    bursty = 1'b1;
    while (sent < total) begin
      set_all(random_side(), $urandom(), $urandom(), $urandom());
      rx_stalls = $urandom_range(0, 3) != 0;
      send_request(jls_pkg::KIND_INIT, 6'($urandom()), 6'($urandom()));
      sent++;
      n = used_side();
      for (int i = 0; i < 14 && sent < total; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45)      kind = jls_pkg::KIND_READ;
        else if (pick < 82) kind = jls_pkg::KIND_SWEEP;
        else if (pick < 88) kind = jls_pkg::KIND_INIT;
        else                kind = jls_pkg::KIND_NONE;
        if (n > 0 && $urandom_range(0, 3) != 0) begin
          row = 6'($urandom_range(0, n-1));
          col = 6'($urandom_range(0, n-1));
        end else begin
          row = 6'($urandom());
          col = 6'($urandom());
        end
        send_request(kind, row, col);
        sent++;
      end
    end
    bursty = 1'b0;
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = jls_pkg::CFG_GRID_SIZE;
    cfg_data     = 32'h0;
    req_ch.valid = 1'b0;
    req_ch.kind  = jls_pkg::KIND_NONE;
    req_ch.row   = 6'h0;
    req_ch.col   = 6'h0;
    rsp_ch.ready = 1'b0;
    errors       = 0;
    cycle_count  = 0;
    hold_cycles  = 0;
    rx_stalls    = 1'b0;
    bursty       = 1'b0;
    burst_left   = 0;
    n_sweeps = 0; n_reads = 0; n_inits = 0; n_writes = 0;
    live_bank    = 1'b0;
    sweeps_done  = 16'h0;
    side_reg     = 7'd4;
    init_reg     = 32'sd536870912;
    rhs_reg      = 32'sd42949673;
    step_reg     = 31'd214748365;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_defaults();
    test_special_cases();
    test_backpressure();
    test_random(108);

    drain_results();
    repeat (50) @(posedge clk);
    $display("covered %0d inits, %0d sweeps, %0d reads and %0d register writes",
             n_inits, n_sweeps, n_reads, n_writes);
    $display("in %0d cycles, with burst gaps, receiver stalls and a long hold-off",
             cycle_count);
    if (errors == 0) begin
      $display("jacobi_laplace_sweep regression: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("jacobi_laplace_sweep regression: fail");
    end
    $finish;
  end

endmodule
